>>> rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, constants and tables for the Gregorian date counter
// Field widths, opcodes, month tables and the controller/datapath links.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int EPOCH_W      = 22;
    localparam int ADV_W        = 16;
    // Bits of advance_days that count; kept at or below ADV_W
    localparam int ADVANCE_BITS = 16;
    // Century quotient of a 14-bit year
    localparam int CENT_W       = 8;
    // Wide enough for the epoch sum before the final truncation
    localparam int SUM_W        = EPOCH_W + 1;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_MIN   = DAY_W'(1);

    // y / 100 as (y * 5243) >> 19, exact for every 14-bit year
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = YEAR_W + 13;

    localparam int EPOCH_BIAS = 429;

    // Opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [YEAR_W-1:0]  load_year;
        logic [MONTH_W-1:0] load_month;
        logic [DAY_W-1:0]   load_day;
        logic [ADV_W-1:0]   advance_days;
    } req_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [DAY_W-1:0]   cur_day;
        logic               is_leap;
        logic [EPOCH_W-1:0] days_since_epoch;
    } rsp_word_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // take the request word
        logic div_epoch;   // divide the March-based year, else the current year
        logic div_en;      // register the century quotient
        logic set_leap;    // leap flag from year and quotient
        logic clamp_day;   // limit day to the month length
        logic step;        // advance one day
        logic sum_en;      // register the epoch day count
        logic out_load;    // hand the result to the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;  // no days left to step
        logic year_roll;   // a step now would enter a new year
        logic out_free;    // output register can take a word
    } dp_status_t;

    // Days in month m (1..12)
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
            default:             len = DAY_W'(31);
        endcase
        return len;
    endfunction

    // (306 * (m' + 1)) / 10 with January and February as months 13 and 14
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] off;
        case (m)
            4'd1:    off = 9'd428;
            4'd2:    off = 9'd459;
            4'd3:    off = 9'd122;
            4'd4:    off = 9'd153;
            4'd5:    off = 9'd183;
            4'd6:    off = 9'd214;
            4'd7:    off = 9'd244;
            4'd8:    off = 9'd275;
            4'd9:    off = 9'd306;
            4'd10:   off = 9'd336;
            4'd11:   off = 9'd367;
            default: off = 9'd397;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/gdc_req_if.sv
// ----------------------------------------------------------------------------
// gdc_req_if: request channel of the date counter
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface gdc_req_if;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [gdc_pkg::YEAR_W-1:0]   load_year;
    logic [gdc_pkg::MONTH_W-1:0]  load_month;
    logic [gdc_pkg::DAY_W-1:0]    load_day;
    logic [gdc_pkg::ADV_W-1:0]    advance_days;

    modport source (
        output valid, operation, load_year, load_month, load_day, advance_days,
        input  ready
    );

    modport sink (
        input  valid, operation, load_year, load_month, load_day, advance_days,
        output ready
    );

endinterface

>>> rtl/gdc_rsp_if.sv
// ----------------------------------------------------------------------------
// gdc_rsp_if: response channel of the date counter
// Valid/ready handshake carrying one date word.
// ----------------------------------------------------------------------------
interface gdc_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [gdc_pkg::YEAR_W-1:0]   cur_year;
    logic [gdc_pkg::MONTH_W-1:0]  cur_month;
    logic [gdc_pkg::DAY_W-1:0]    cur_day;
    logic                         is_leap;
    logic [gdc_pkg::EPOCH_W-1:0]  days_since_epoch;

    modport source (
        output valid, cur_year, cur_month, cur_day, is_leap, days_since_epoch,
        input  ready
    );

    modport sink (
        input  valid, cur_year, cur_month, cur_day, is_leap, days_since_epoch,
        output ready
    );

endinterface

>>> rtl/gregorian_date_counter.sv
// ----------------------------------------------------------------------------
// gregorian_date_counter: Gregorian calendar day counter
// Load: year divide, leap flag, day clamp, then epoch divide and sum. Advance
// by N days: N day steps (leap flag refresh through the century divider at
// each new year), then epoch divide and sum. One word in flight; the next word
// is accepted while a result waits. Reset (async, rst_n low) sets 0001-01-01,
// not leap, no result pending.
module gregorian_date_counter (
    input  logic       clk,
    input  logic       rst_n,
    gdc_req_if.sink    req,
    gdc_rsp_if.source  rsp
);

    gdc_pkg::req_word_t  req_word;
    gdc_pkg::rsp_word_t  rsp_word;
    gdc_pkg::dp_cmd_t    cmd;
    gdc_pkg::dp_status_t status;

    assign req_word.operation    = req.operation;
    assign req_word.load_year    = req.load_year;
    assign req_word.load_month   = req.load_month;
    assign req_word.load_day     = req.load_day;
    assign req_word.advance_days = req.advance_days;

    gdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.operation),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gdc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .status    (status),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_word  (rsp_word)
    );

    assign rsp.cur_year         = rsp_word.cur_year;
    assign rsp.cur_month        = rsp_word.cur_month;
    assign rsp.cur_day          = rsp_word.cur_day;
    assign rsp.is_leap          = rsp_word.is_leap;
    assign rsp.days_since_epoch = rsp_word.days_since_epoch;

endmodule

>>> rtl/gdc_datapath.sv
// ----------------------------------------------------------------------------
// gdc_datapath: date registers, day stepper, century divider, epoch adder
// Acts on commands from the controller, reports status back.
// ----------------------------------------------------------------------------
module gdc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gdc_pkg::req_word_t   req_word,
    input  gdc_pkg::dp_cmd_t     cmd,
    output gdc_pkg::dp_status_t  status,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output gdc_pkg::rsp_word_t   rsp_word
);

    logic [gdc_pkg::YEAR_W-1:0]       year_reg,  year_next;
    logic [gdc_pkg::MONTH_W-1:0]      month_reg, month_next;
    logic [gdc_pkg::DAY_W-1:0]        day_reg,   day_next;
    logic                             leap_reg,  leap_next;
    logic [gdc_pkg::ADVANCE_BITS-1:0] count_reg, count_next;
    logic [gdc_pkg::CENT_W-1:0]       cent_reg;
    logic [gdc_pkg::EPOCH_W-1:0]      epoch_reg;
    logic                             out_valid_reg;
    gdc_pkg::rsp_word_t               out_reg;

    logic [gdc_pkg::DAY_W-1:0]        cur_len;
    logic                             month_end;
    logic [gdc_pkg::YEAR_W-1:0]       year_adj;
    logic [gdc_pkg::YEAR_W-1:0]       div_in;
    logic [gdc_pkg::DIV100_PW-1:0]    div_prod;
    logic [gdc_pkg::YEAR_W:0]         cent_x100;
    logic                             leap_calc;
    logic [gdc_pkg::SUM_W-1:0]        epoch_sum;
    logic [gdc_pkg::YEAR_W-1:0]       ld_year;
    logic [gdc_pkg::MONTH_W-1:0]      ld_month;
    logic [gdc_pkg::DAY_W-1:0]        ld_day;

    // Load-field range limits
    always_comb
    begin
        if (req_word.load_year < gdc_pkg::YEAR_MIN)
            ld_year = gdc_pkg::YEAR_MIN;
        else if (req_word.load_year > gdc_pkg::YEAR_MAX)
            ld_year = gdc_pkg::YEAR_MAX;
        else
            ld_year = req_word.load_year;

        if (req_word.load_month < gdc_pkg::MONTH_MIN)
            ld_month = gdc_pkg::MONTH_MIN;
        else if (req_word.load_month > gdc_pkg::MONTH_MAX)
            ld_month = gdc_pkg::MONTH_MAX;
        else
            ld_month = req_word.load_month;

        ld_day = (req_word.load_day < gdc_pkg::DAY_MIN) ? gdc_pkg::DAY_MIN
                                                         : req_word.load_day;
    end

    // Day stepper status
    assign cur_len   = gdc_pkg::month_len(leap_reg, month_reg);
    assign month_end = (day_reg >= cur_len);

    // Century quotient by reciprocal multiply
    assign year_adj = (month_reg <= gdc_pkg::MONTH_FEB) ? (year_reg - gdc_pkg::YEAR_MIN)
                                                         : year_reg;
    assign div_in   = cmd.div_epoch ? year_adj : year_reg;
    assign div_prod = gdc_pkg::DIV100_PW'(div_in) *
                      gdc_pkg::DIV100_PW'(gdc_pkg::DIV100_MUL);

    // Leap rule from year and its registered century quotient
    assign cent_x100 = (gdc_pkg::YEAR_W+1)'(cent_reg) * (gdc_pkg::YEAR_W+1)'(100);
    assign leap_calc = (year_reg[1:0] == 2'b00) &&
                       ((cent_x100 != {1'b0, year_reg}) || (cent_reg[1:0] == 2'b00));

    // Day count since the epoch, March-based year
    assign epoch_sum = gdc_pkg::SUM_W'(year_adj) * gdc_pkg::SUM_W'(365)
                     + gdc_pkg::SUM_W'(year_adj >> 2)
                     - gdc_pkg::SUM_W'(cent_reg)
                     + gdc_pkg::SUM_W'(cent_reg >> 2)
                     + gdc_pkg::SUM_W'(gdc_pkg::month_offset(month_reg))
                     + gdc_pkg::SUM_W'(day_reg)
                     - gdc_pkg::SUM_W'(gdc_pkg::EPOCH_BIAS);

    // Date register updates
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        leap_next  = leap_reg;
        count_next = count_reg;
        if (cmd.capture)
        begin
            if (req_word.operation == gdc_pkg::OP_LOAD)
            begin
                year_next  = ld_year;
                month_next = ld_month;
                day_next   = ld_day;
            end
            else
                count_next = req_word.advance_days[gdc_pkg::ADVANCE_BITS-1:0];
        end
        if (cmd.set_leap)
            leap_next = leap_calc;
        if (cmd.clamp_day && (day_reg > cur_len))
            day_next = cur_len;
        if (cmd.step)
        begin
            count_next = count_reg - gdc_pkg::ADVANCE_BITS'(1);
            if (!month_end)
                day_next = day_reg + gdc_pkg::DAY_MIN;
            else
            begin
                day_next = gdc_pkg::DAY_MIN;
                if (month_reg == gdc_pkg::MONTH_MAX)
                begin
                    month_next = gdc_pkg::MONTH_MIN;
                    year_next  = (year_reg == gdc_pkg::YEAR_MAX) ? gdc_pkg::YEAR_MIN
                                                                  : year_reg + gdc_pkg::YEAR_MIN;
                end
                else
                    month_next = month_reg + gdc_pkg::MONTH_MIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= gdc_pkg::YEAR_MIN;
            month_reg     <= gdc_pkg::MONTH_MIN;
            day_reg       <= gdc_pkg::DAY_MIN;
            leap_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            leap_reg  <= leap_next;
            count_reg <= count_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
            cent_reg <= div_prod[gdc_pkg::DIV100_SHIFT +: gdc_pkg::CENT_W];
        if (cmd.sum_en)
            epoch_reg <= epoch_sum[gdc_pkg::EPOCH_W-1:0];
        if (cmd.out_load)
        begin
            out_reg.cur_year         <= year_reg;
            out_reg.cur_month        <= month_reg;
            out_reg.cur_day          <= day_reg;
            out_reg.is_leap          <= leap_reg;
            out_reg.days_since_epoch <= epoch_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.year_roll  = month_end && (month_reg == gdc_pkg::MONTH_MAX);
    assign status.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

endmodule

>>> rtl/gdc_ctrl.sv
// ----------------------------------------------------------------------------
// gdc_ctrl: sequencer of the date counter
// Walks load, step, leap and epoch phases and issues datapath commands.
// ----------------------------------------------------------------------------
module gdc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_op,
    output logic                 req_ready,
    input  gdc_pkg::dp_status_t  status,
    output gdc_pkg::dp_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVY  = 4'd1;
    localparam logic [3:0] S_LEAP  = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_DIVE  = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       mode_reg,  mode_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    mode_next   = req_op;
                    state_next  = (req_op == gdc_pkg::OP_LOAD) ? S_DIVY : S_STEP;
                end
            end
            S_DIVY:
            begin
                cmd.div_en = 1'b1;
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                cmd.set_leap = 1'b1;
                state_next   = (mode_reg == gdc_pkg::OP_LOAD) ? S_CLAMP : S_STEP;
            end
            S_CLAMP:
            begin
                cmd.clamp_day = 1'b1;
                state_next    = S_DIVE;
            end
            S_STEP:
            begin
                if (status.count_zero)
                    state_next = S_DIVE;
                else
                begin
                    cmd.step = 1'b1;
                    // new year: refresh the leap flag before the next step
                    if (status.year_roll)
                        state_next = S_DIVY;
                end
            end
            S_DIVE:
            begin
                cmd.div_epoch = 1'b1;
                cmd.div_en    = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                cmd.div_epoch = 1'b1;
                cmd.sum_en    = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= gdc_pkg::OP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

>>> bench/date_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_check_pkg: calendar predictor and result tracker for the date counter
// Holds a private copy of the date, works out the date word each command word
// should produce, queues it, and compares returned date words field by field.
// ----------------------------------------------------------------------------
package date_check_pkg;

    import gdc_pkg::*;

    // Days in the full 0001-01-01 .. 9999-12-31 range, after which the year wraps
    localparam int unsigned ERA_DAYS = 3652059;

    // 400/100/4 rule
    function automatic bit leap_year(input int unsigned y);
        if (y % 400 == 0)
            return 1'b1;
        if (y % 100 == 0)
            return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic int unsigned days_in_month(input bit leap, input int unsigned m);
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // March-based count: January and February belong to the previous year
    function automatic int unsigned epoch_day(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
        int unsigned yy;
        int unsigned mm;
        yy = y;
        mm = m;
        if (mm <= 2)
        begin
            yy = yy - 1;
            mm = mm + 12;
        end
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (306 * (mm + 1)) / 10 + d - 429;
    endfunction

    class date_tracker;

        int unsigned year;
        int unsigned month;
        int unsigned day;
        bit          leap;
        rsp_word_t   expected_dates[$];
        int          errors;

        function new();
            year   = 1;
            month  = 1;
            day    = 1;
            leap   = 1'b0;
            errors = 0;
        endfunction

        // Month length follows the leap flag held for the current year
        function void step_day();
            day = day + 1;
            if (day > days_in_month(leap, month))
            begin
                day   = 1;
                month = month + 1;
            end
            if (month > 12)
            begin
                month = 1;
                year  = year + 1;
                if (year > int'(YEAR_MAX))
                    year = 1;
            end
            leap = leap_year(year);
        endfunction

        // Accepted command word: update the date and queue the date word it yields
        function void note_request(input req_word_t w);
            rsp_word_t   e;
            int unsigned y;
            int unsigned m;
            int unsigned d;
            int unsigned len;
            int unsigned n;
            if (w.operation == OP_LOAD)
            begin
                y = int'(w.load_year);
                m = int'(w.load_month);
                d = int'(w.load_day);
                if (y < int'(YEAR_MIN))
                    y = int'(YEAR_MIN);
                if (y > int'(YEAR_MAX))
                    y = int'(YEAR_MAX);
                if (m < int'(MONTH_MIN))
                    m = int'(MONTH_MIN);
                if (m > int'(MONTH_MAX))
                    m = int'(MONTH_MAX);
                year  = y;
                month = m;
                leap  = leap_year(y);
                len   = days_in_month(leap, m);
                if (d < 1)
                    d = 1;
                if (d > len)
                    d = len;
                day = d;
            end
            else
            begin
                n = (int'(w.advance_days) & ((1 << ADVANCE_BITS) - 1)) % ERA_DAYS;
                repeat (n) step_day();
            end
            e.cur_year         = YEAR_W'(year);
            e.cur_month        = MONTH_W'(month);
            e.cur_day          = DAY_W'(day);
            e.is_leap          = leap;
            e.days_since_epoch = EPOCH_W'(epoch_day(year, month, day));
            expected_dates.push_back(e);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Returned date word against the oldest queued one
        function void check_date(input rsp_word_t got);
            rsp_word_t e;
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected date word %0d-%0d-%0d", $time,
                         got.cur_year, got.cur_month, got.cur_day);
                errors++;
                return;
            end
            e = expected_dates.pop_front();
            compare_field("cur_year", int'(e.cur_year), int'(got.cur_year));
            compare_field("cur_month", int'(e.cur_month), int'(got.cur_month));
            compare_field("cur_day", int'(e.cur_day), int'(got.cur_day));
            compare_field("is_leap", int'(e.is_leap), int'(got.is_leap));
            compare_field("days_since_epoch", int'(e.days_since_epoch),
                          int'(got.days_since_epoch));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

    endclass

endpackage

>>> bench/gregorian_date_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_counter_tb: self-checking bench for the Gregorian date counter
// Directed loads and advances hit clamping, leap rules and the 9999 wrap, then
// random command words run in bursts against a stalling receiver; every date
// word is checked against a private calendar predictor.
// ----------------------------------------------------------------------------
module gregorian_date_counter_tb;

    import gdc_pkg::*;
    import date_check_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned cycle_budget = 20000;
    int unsigned burst_left = 0;
    date_tracker tracker;

    gdc_req_if req();
    gdc_rsp_if rsp();

    gregorian_date_counter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog; the budget grows with every command word sent
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check each accepted date word
    always @(posedge clk)
    begin : result_check
        rsp_word_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.cur_year         = rsp.cur_year;
            got.cur_month        = rsp.cur_month;
            got.cur_day          = rsp.cur_day;
            got.is_leap          = rsp.is_leap;
            got.days_since_epoch = rsp.days_since_epoch;
            tracker.check_date(got);
        end
    end

    // Receiver: ready replays a 16-bit pattern, then a new pattern is drawn at random
    initial
    begin : receiver
        logic [15:0] pattern;
        int          phase;
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0:       pattern = 16'hFFFF;
                1:       pattern = 16'h8001;
                default: pattern = 16'($urandom) | 16'h0101;
            endcase
            for (phase = 0; phase < 64; phase++)
            begin
                rsp.ready <= pattern[phase % 16];
                @(posedge clk);
            end
        end
    end

    // Load word; the advance count is a don't-care and gets random bits
    function automatic req_word_t load_word(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
        req_word_t w;
        w.operation    = OP_LOAD;
        w.load_year    = YEAR_W'(y);
        w.load_month   = MONTH_W'(m);
        w.load_day     = DAY_W'(d);
        w.advance_days = ADV_W'($urandom);
        return w;
    endfunction

    // Advance word; load fields are don't-cares and get random bits
    function automatic req_word_t advance_word(input int unsigned n);
        req_word_t w;
        w.operation    = OP_ADVANCE;
        w.load_year    = YEAR_W'($urandom);
        w.load_month   = MONTH_W'($urandom);
        w.load_day     = DAY_W'($urandom);
        w.advance_days = ADV_W'(n);
        return w;
    endfunction

    // Mostly valid dates biased to century years, the ends of the year range and month ends
    function automatic req_word_t random_load();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        if ($urandom_range(0, 9) == 0)
            return load_word($urandom, $urandom, $urandom);
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(1, 99) * 100;
            1:       y = $urandom_range(9990, 9999);
            2:       y = $urandom_range(1, 30);
            default: y = $urandom_range(1, 9999);
        endcase
        m   = $urandom_range(1, 12);
        len = days_in_month(leap_year(y), m);
        case ($urandom_range(0, 3))
            0:       d = len;
            1:       d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        return load_word(y, m, d);
    endfunction

    // Step counts mostly short; a few long ones exercise the upper bits
    function automatic req_word_t random_advance();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return advance_word($urandom_range(0, 40));
        if (pick < 85)
            return advance_word($urandom_range(41, 800));
        if (pick < 98)
            return advance_word($urandom_range(801, 12000));
        return advance_word($urandom_range(12001, 65535));
    endfunction

    // Present one word, hold until accepted, then maybe end the burst
    task automatic send_word(input req_word_t w);
        int unsigned gap;
        req.valid        <= 1'b1;
        req.operation    <= w.operation;
        req.load_year    <= w.load_year;
        req.load_month   <= w.load_month;
        req.load_day     <= w.load_day;
        req.advance_days <= w.advance_days;
        if (w.operation == OP_ADVANCE)
            cycle_budget += 4 * (2 * int'(w.advance_days) + 100);
        else
            cycle_budget += 400;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        tracker.note_request(w);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap        = $urandom_range(1, 12);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every queued date word has come back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        tracker          = new();
        req.valid        = 1'b0;
        req.operation    = OP_LOAD;
        req.load_year    = '0;
        req.load_month   = '0;
        req.load_day     = '0;
        req.advance_days = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset date, clamping of every load field, leap rules, wrap, long step
        send_word(advance_word(0));
        send_word(load_word(0, 0, 0));
        send_word(load_word(16383, 15, 31));
        send_word(advance_word(1));
        send_word(load_word(9999, 12, 31));
        send_word(advance_word(65535));
        send_word(load_word(2000, 2, 31));
        send_word(load_word(1900, 2, 29));
        send_word(advance_word(1));
        send_word(load_word(2000, 2, 28));
        send_word(advance_word(1));
        send_word(advance_word(1));
        send_word(load_word(2023, 4, 31));
        send_word(advance_word(0));
        send_word(load_word(2024, 12, 31));
        send_word(advance_word(366));
        send_word(load_word(1, 1, 1));
        send_word(load_word(9999, 1, 1));
        send_word(load_word(2100, 2, 29));
        send_word(advance_word(31));
        drain();

        // Random mix, with an occasional full hold-off
        for (i = 0; i < 450; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_word(random_load());
            else
                send_word(random_advance());
            if ($urandom_range(0, 99) == 0)
                drain();
        end

        drain();
        repeat (32) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
